// ----- rtl/core/tbi_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register indexes and flag types for the triangle barycentric unit.
package tbi_pkg;

   // Coordinate and arithmetic widths
   localparam int COORD_W      = 16;
   localparam int DIFF_W       = COORD_W + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int SUM_W        = PROD_W + 1;
   localparam int MAG_W        = PROD_W;
   localparam int FRAC_W       = 16;
   localparam int WEIGHT_W     = 32;
   localparam int LOW_W        = WEIGHT_W - FRAC_W;

   // Pipeline shape: front end, divider stages, output register
   localparam int DIV_STEPS    = 2;
   localparam int DIV_STAGES   = WEIGHT_W / DIV_STEPS;
   localparam int FRONT_STAGES = 4;
   localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

   // Configuration register map
   localparam int CSR_IDX_W    = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VERT_A_X = 3'd0,
      CSR_VERT_A_Y = 3'd1,
      CSR_VERT_B_X = 3'd2,
      CSR_VERT_B_Y = 3'd3,
      CSR_VERT_C_X = 3'd4,
      CSR_VERT_C_Y = 3'd5
   } csr_index_type;

   // Saturation limits for the unsigned quotient magnitude
   localparam logic [WEIGHT_W-1:0] LIM_POS = {1'b0, {(WEIGHT_W-1){1'b1}}};
   localparam logic [WEIGHT_W-1:0] LIM_NEG = {1'b1, {(WEIGHT_W-1){1'b0}}};

   // Per-lane divider side flags
   typedef struct packed {
      logic neg;
      logic sat;
   } div_flag_type;

   // Per-pixel result flags
   typedef struct packed {
      logic in_tri;
      logic degenerate;
   } pix_flag_type;

endpackage

// ----- rtl/core/tbi_div_lane.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider lane: edge magnitude scaled by 2^FRAC_W over area magnitude.
module tbi_div_lane (
   input  logic                                 clock,
   input  logic [tbi_pkg::DIV_STAGES-1:0]       adv,
   input  logic [tbi_pkg::MAG_W-1:0]            num_mag,
   input  logic [tbi_pkg::MAG_W-1:0]            den_mag,
   input  tbi_pkg::div_flag_type                flag_in,
   output logic [tbi_pkg::WEIGHT_W-1:0]         quot,
   output tbi_pkg::div_flag_type                flag_out
);

   // Partial remainder, dividend/quotient shift word, divisor and flags per stage
   logic [tbi_pkg::MAG_W-1:0]    rem_ff  [tbi_pkg::DIV_STAGES];
   logic [tbi_pkg::WEIGHT_W-1:0] quo_ff  [tbi_pkg::DIV_STAGES];
   logic [tbi_pkg::MAG_W-1:0]    den_ff  [tbi_pkg::DIV_STAGES];
   tbi_pkg::div_flag_type        flag_ff [tbi_pkg::DIV_STAGES];

   // Upper dividend bits seed the remainder; lower bits shift in one per step
   logic [tbi_pkg::MAG_W-1:0]    rem_seed;
   logic [tbi_pkg::WEIGHT_W-1:0] quo_seed;

   assign rem_seed = tbi_pkg::MAG_W'(num_mag >> tbi_pkg::LOW_W);
   assign quo_seed = {num_mag[tbi_pkg::LOW_W-1:0], {tbi_pkg::FRAC_W{1'b0}}};

   for (genvar s = 0; s < tbi_pkg::DIV_STAGES; s++) begin : g_stage
      logic [tbi_pkg::MAG_W-1:0]    rem_src;
      logic [tbi_pkg::WEIGHT_W-1:0] quo_src;
      logic [tbi_pkg::MAG_W-1:0]    den_src;
      tbi_pkg::div_flag_type        flag_src;
      logic [tbi_pkg::MAG_W-1:0]    rem_in;
      logic [tbi_pkg::WEIGHT_W-1:0] quo_in;

      if (s == 0) begin : g_first
         assign rem_src  = rem_seed;
         assign quo_src  = quo_seed;
         assign den_src  = den_mag;
         assign flag_src = flag_in;
      end else begin : g_next
         assign rem_src  = rem_ff[s-1];
         assign quo_src  = quo_ff[s-1];
         assign den_src  = den_ff[s-1];
         assign flag_src = flag_ff[s-1];
      end

      // DIV_STEPS subtract-and-shift steps per stage
      always_comb begin : step
         logic [tbi_pkg::MAG_W:0]      trial;
         logic [tbi_pkg::MAG_W-1:0]    rem;
         logic [tbi_pkg::WEIGHT_W-1:0] quo;
         logic                         take;
         rem = rem_src;
         quo = quo_src;
         for (int i = 0; i < tbi_pkg::DIV_STEPS; i++) begin
            trial = {rem, quo[tbi_pkg::WEIGHT_W-1]};
            take  = (trial >= {1'b0, den_src});
            rem   = take ? tbi_pkg::MAG_W'(trial - {1'b0, den_src})
                         : trial[tbi_pkg::MAG_W-1:0];
            quo   = {quo[tbi_pkg::WEIGHT_W-2:0], take};
         end
         rem_in = rem;
         quo_in = quo;
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            rem_ff[s]  <= rem_in;
            quo_ff[s]  <= quo_in;
            den_ff[s]  <= den_src;
            flag_ff[s] <= flag_src;
         end
      end
   end

   assign quot     = quo_ff[tbi_pkg::DIV_STAGES-1];
   assign flag_out = flag_ff[tbi_pkg::DIV_STAGES-1];

endmodule

// ----- rtl/core/triangle_barycentric_inside_test_unit.sv -----
`timescale 1ns / 1ps
// Top level: edge-function point-in-triangle test with barycentric weights.
//
// Usage:
//  - csr_* writes the six vertex coordinates (signed 12.4) by index 0..5;
//    indexes beyond that are dropped. csr_ready is always high. Write only
//    while no beat is in flight.
//  - req_* carries one query point per beat; rsp_* returns one result per
//    beat: three Q15.16 weights, inside and degenerate flags and the
//    triangle's bounding box.
//  - Pipeline: 4 front stages for differences, products, sums and
//    magnitudes, 16 divider stages of 2 quotient bits each, and
//    1 output register.
//  - Throughput: one beat per cycle unless a full pipeline stalls on rsp_ready;
//    the three divider lanes run in parallel; new points are taken while req_ready is high.
//  - Reset clears all stage valids and zeroes the vertex registers.
//  - When rsp_ready is low, each stage holds only if the stage after it is
//    full, so empty slots fill up before req_ready drops; nothing is lost
//    or repeated.
//  - A zero-area triangle gives degenerate set, zero weights, inside clear.
module triangle_barycentric_inside_test_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbi_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tbi_pkg::COORD_W-1:0]         csr_wdata,
   // Query points
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [tbi_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [tbi_pkg::COORD_W-1:0]  req_point_y,
   // Results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [tbi_pkg::WEIGHT_W-1:0] rsp_weight_a,
   output logic signed [tbi_pkg::WEIGHT_W-1:0] rsp_weight_b,
   output logic signed [tbi_pkg::WEIGHT_W-1:0] rsp_weight_c,
   output logic                                rsp_inside_res,
   output logic                                rsp_degenerate,
   output logic signed [tbi_pkg::COORD_W-1:0]  rsp_box_min_x,
   output logic signed [tbi_pkg::COORD_W-1:0]  rsp_box_min_y,
   output logic signed [tbi_pkg::COORD_W-1:0]  rsp_box_max_x,
   output logic signed [tbi_pkg::COORD_W-1:0]  rsp_box_max_y
);

   localparam int LAST = tbi_pkg::PIPE_STAGES - 1;

   // ------------------------------------------------------------------
   // Vertex registers
   // ------------------------------------------------------------------
   logic signed [tbi_pkg::COORD_W-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff <= '0;
         ay_ff <= '0;
         bx_ff <= '0;
         by_ff <= '0;
         cx_ff <= '0;
         cy_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (tbi_pkg::csr_index_type'(csr_index))
            tbi_pkg::CSR_VERT_A_X: ax_ff <= csr_wdata;
            tbi_pkg::CSR_VERT_A_Y: ay_ff <= csr_wdata;
            tbi_pkg::CSR_VERT_B_X: bx_ff <= csr_wdata;
            tbi_pkg::CSR_VERT_B_Y: by_ff <= csr_wdata;
            tbi_pkg::CSR_VERT_C_X: cx_ff <= csr_wdata;
            tbi_pkg::CSR_VERT_C_Y: cy_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Bounding box follows the vertex registers; stable while beats fly
   function automatic logic signed [tbi_pkg::COORD_W-1:0] min3(
      input logic signed [tbi_pkg::COORD_W-1:0] a,
      input logic signed [tbi_pkg::COORD_W-1:0] b,
      input logic signed [tbi_pkg::COORD_W-1:0] c);
      logic signed [tbi_pkg::COORD_W-1:0] m;
      m = (a < b) ? a : b;
      return (m < c) ? m : c;
   endfunction

   function automatic logic signed [tbi_pkg::COORD_W-1:0] max3(
      input logic signed [tbi_pkg::COORD_W-1:0] a,
      input logic signed [tbi_pkg::COORD_W-1:0] b,
      input logic signed [tbi_pkg::COORD_W-1:0] c);
      logic signed [tbi_pkg::COORD_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

   logic signed [tbi_pkg::COORD_W-1:0] box_min_x_ff, box_min_y_ff;
   logic signed [tbi_pkg::COORD_W-1:0] box_max_x_ff, box_max_y_ff;

   always_ff @(posedge clock) begin
      box_min_x_ff <= min3(ax_ff, bx_ff, cx_ff);
      box_min_y_ff <= min3(ay_ff, by_ff, cy_ff);
      box_max_x_ff <= max3(ax_ff, bx_ff, cx_ff);
      box_max_y_ff <= max3(ay_ff, by_ff, cy_ff);
   end

   // ------------------------------------------------------------------
   // Stage valids and per-stage advance (bubbles collapse on stall)
   // ------------------------------------------------------------------
   logic [LAST:0] v_ff, v_in, adv;

   assign adv[LAST] = !v_ff[LAST] || rsp_ready;
   for (genvar k = 0; k < LAST; k++) begin : g_adv
      assign adv[k] = !v_ff[k] || adv[k+1];
   end

   assign v_in[0] = adv[0] ? req_valid : v_ff[0];
   for (genvar k = 1; k <= LAST; k++) begin : g_vin
      assign v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = v_ff[LAST];

   // ------------------------------------------------------------------
   // Stage 1: coordinate differences
   // ------------------------------------------------------------------
   logic signed [tbi_pkg::DIFF_W-1:0] pa_x_ff, pa_y_ff, pb_x_ff, pb_y_ff, pc_x_ff, pc_y_ff;
   logic signed [tbi_pkg::DIFF_W-1:0] ba_x_ff, ba_y_ff, ca_x_ff, ca_y_ff;
   logic signed [tbi_pkg::DIFF_W-1:0] cb_x_ff, cb_y_ff, ac_x_ff, ac_y_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         pa_x_ff <= tbi_pkg::DIFF_W'(req_point_x) - tbi_pkg::DIFF_W'(ax_ff);
         pa_y_ff <= tbi_pkg::DIFF_W'(req_point_y) - tbi_pkg::DIFF_W'(ay_ff);
         pb_x_ff <= tbi_pkg::DIFF_W'(req_point_x) - tbi_pkg::DIFF_W'(bx_ff);
         pb_y_ff <= tbi_pkg::DIFF_W'(req_point_y) - tbi_pkg::DIFF_W'(by_ff);
         pc_x_ff <= tbi_pkg::DIFF_W'(req_point_x) - tbi_pkg::DIFF_W'(cx_ff);
         pc_y_ff <= tbi_pkg::DIFF_W'(req_point_y) - tbi_pkg::DIFF_W'(cy_ff);
         ba_x_ff <= tbi_pkg::DIFF_W'(bx_ff) - tbi_pkg::DIFF_W'(ax_ff);
         ba_y_ff <= tbi_pkg::DIFF_W'(by_ff) - tbi_pkg::DIFF_W'(ay_ff);
         ca_x_ff <= tbi_pkg::DIFF_W'(cx_ff) - tbi_pkg::DIFF_W'(ax_ff);
         ca_y_ff <= tbi_pkg::DIFF_W'(cy_ff) - tbi_pkg::DIFF_W'(ay_ff);
         cb_x_ff <= tbi_pkg::DIFF_W'(cx_ff) - tbi_pkg::DIFF_W'(bx_ff);
         cb_y_ff <= tbi_pkg::DIFF_W'(cy_ff) - tbi_pkg::DIFF_W'(by_ff);
         ac_x_ff <= tbi_pkg::DIFF_W'(ax_ff) - tbi_pkg::DIFF_W'(cx_ff);
         ac_y_ff <= tbi_pkg::DIFF_W'(ay_ff) - tbi_pkg::DIFF_W'(cy_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: cross-product terms, one multiply each
   // ------------------------------------------------------------------
   logic signed [tbi_pkg::PROD_W-1:0] m0a_ff, m0b_ff, m1a_ff, m1b_ff;
   logic signed [tbi_pkg::PROD_W-1:0] m2a_ff, m2b_ff, mra_ff, mrb_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         m0a_ff <= tbi_pkg::PROD_W'(pb_y_ff) * tbi_pkg::PROD_W'(cb_x_ff);
         m0b_ff <= tbi_pkg::PROD_W'(pb_x_ff) * tbi_pkg::PROD_W'(cb_y_ff);
         m1a_ff <= tbi_pkg::PROD_W'(pc_y_ff) * tbi_pkg::PROD_W'(ac_x_ff);
         m1b_ff <= tbi_pkg::PROD_W'(pc_x_ff) * tbi_pkg::PROD_W'(ac_y_ff);
         m2a_ff <= tbi_pkg::PROD_W'(pa_y_ff) * tbi_pkg::PROD_W'(ba_x_ff);
         m2b_ff <= tbi_pkg::PROD_W'(pa_x_ff) * tbi_pkg::PROD_W'(ba_y_ff);
         mra_ff <= tbi_pkg::PROD_W'(ba_x_ff) * tbi_pkg::PROD_W'(ca_y_ff);
         mrb_ff <= tbi_pkg::PROD_W'(ba_y_ff) * tbi_pkg::PROD_W'(ca_x_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: edge values and signed double area
   // ------------------------------------------------------------------
   logic signed [tbi_pkg::SUM_W-1:0] e0_ff, e1_ff, e2_ff, area_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         e0_ff   <= tbi_pkg::SUM_W'(m0a_ff) - tbi_pkg::SUM_W'(m0b_ff);
         e1_ff   <= tbi_pkg::SUM_W'(m1a_ff) - tbi_pkg::SUM_W'(m1b_ff);
         e2_ff   <= tbi_pkg::SUM_W'(m2a_ff) - tbi_pkg::SUM_W'(m2b_ff);
         area_ff <= tbi_pkg::SUM_W'(mra_ff) - tbi_pkg::SUM_W'(mrb_ff);
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: magnitudes, signs, saturation pre-check, inside test
   // ------------------------------------------------------------------
   function automatic logic [tbi_pkg::MAG_W-1:0] abs_mag(
      input logic signed [tbi_pkg::SUM_W-1:0] v);
      logic [tbi_pkg::SUM_W-1:0] n;
      n = v[tbi_pkg::SUM_W-1] ? (~v + 1'b1) : v;
      return n[tbi_pkg::MAG_W-1:0];
   endfunction

   // Quotient reaches 2^WEIGHT_W exactly when num >= den * 2^FRAC_W
   function automatic logic too_big(
      input logic [tbi_pkg::MAG_W-1:0] num,
      input logic [tbi_pkg::MAG_W-1:0] den);
      return {{tbi_pkg::FRAC_W{1'b0}}, num} >= {den, {tbi_pkg::FRAC_W{1'b0}}};
   endfunction

   logic [tbi_pkg::MAG_W-1:0] n0_mag, n1_mag, n2_mag, d_mag;
   logic                      area_neg, degen, in_tri;

   always_comb begin
      n0_mag   = abs_mag(e0_ff);
      n1_mag   = abs_mag(e1_ff);
      n2_mag   = abs_mag(e2_ff);
      d_mag    = abs_mag(area_ff);
      area_neg = area_ff[tbi_pkg::SUM_W-1];
      degen    = (area_ff == '0);
      in_tri   = !degen
               && ((e0_ff == '0) || (e0_ff[tbi_pkg::SUM_W-1] == area_neg))
               && ((e1_ff == '0) || (e1_ff[tbi_pkg::SUM_W-1] == area_neg))
               && ((e2_ff == '0) || (e2_ff[tbi_pkg::SUM_W-1] == area_neg));
   end

   logic [tbi_pkg::MAG_W-1:0] n0_ff, n1_ff, n2_ff, d_ff;
   tbi_pkg::div_flag_type     f0_ff, f1_ff, f2_ff;
   tbi_pkg::pix_flag_type     pix_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         n0_ff             <= n0_mag;
         n1_ff             <= n1_mag;
         n2_ff             <= n2_mag;
         d_ff              <= d_mag;
         f0_ff.neg         <= e0_ff[tbi_pkg::SUM_W-1] ^ area_neg;
         f1_ff.neg         <= e1_ff[tbi_pkg::SUM_W-1] ^ area_neg;
         f2_ff.neg         <= e2_ff[tbi_pkg::SUM_W-1] ^ area_neg;
         f0_ff.sat         <= too_big(n0_mag, d_mag);
         f1_ff.sat         <= too_big(n1_mag, d_mag);
         f2_ff.sat         <= too_big(n2_mag, d_mag);
         pix_ff.in_tri     <= in_tri;
         pix_ff.degenerate <= degen;
      end
   end

   // ------------------------------------------------------------------
   // Divider lanes, one per weight
   // ------------------------------------------------------------------
   logic [tbi_pkg::DIV_STAGES-1:0] div_adv;
   logic [tbi_pkg::WEIGHT_W-1:0]   q0, q1, q2;
   tbi_pkg::div_flag_type          qf0, qf1, qf2;

   assign div_adv = adv[tbi_pkg::FRONT_STAGES +: tbi_pkg::DIV_STAGES];

   tbi_div_lane u_lane_a (
      .clock    (clock),
      .adv      (div_adv),
      .num_mag  (n0_ff),
      .den_mag  (d_ff),
      .flag_in  (f0_ff),
      .quot     (q0),
      .flag_out (qf0)
   );

   tbi_div_lane u_lane_b (
      .clock    (clock),
      .adv      (div_adv),
      .num_mag  (n1_ff),
      .den_mag  (d_ff),
      .flag_in  (f1_ff),
      .quot     (q1),
      .flag_out (qf1)
   );

   tbi_div_lane u_lane_c (
      .clock    (clock),
      .adv      (div_adv),
      .num_mag  (n2_ff),
      .den_mag  (d_ff),
      .flag_in  (f2_ff),
      .quot     (q2),
      .flag_out (qf2)
   );

   // Pixel flags ride alongside the divider stages
   tbi_pkg::pix_flag_type pf_ff [tbi_pkg::DIV_STAGES];

   for (genvar s = 0; s < tbi_pkg::DIV_STAGES; s++) begin : g_pf
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (div_adv[s]) begin
               pf_ff[s] <= pix_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (div_adv[s]) begin
               pf_ff[s] <= pf_ff[s-1];
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Output stage: clamp, apply sign, zero out degenerate triangles
   // ------------------------------------------------------------------
   function automatic logic [tbi_pkg::WEIGHT_W-1:0] finish_weight(
      input logic [tbi_pkg::WEIGHT_W-1:0] q,
      input tbi_pkg::div_flag_type        f,
      input logic                         degen_bit);
      logic [tbi_pkg::WEIGHT_W-1:0] lim;
      logic [tbi_pkg::WEIGHT_W-1:0] m;
      lim = f.neg ? tbi_pkg::LIM_NEG : tbi_pkg::LIM_POS;
      m   = (f.sat || (q > lim)) ? lim : q;
      if (degen_bit) begin
         return '0;
      end
      return f.neg ? (~m + 1'b1) : m;
   endfunction

   tbi_pkg::pix_flag_type             pix_last;
   logic signed [tbi_pkg::WEIGHT_W-1:0] wa_ff, wb_ff, wc_ff;
   tbi_pkg::pix_flag_type             out_flag_ff;

   assign pix_last = pf_ff[tbi_pkg::DIV_STAGES-1];

   always_ff @(posedge clock) begin
      if (adv[LAST]) begin
         wa_ff       <= finish_weight(q0, qf0, pix_last.degenerate);
         wb_ff       <= finish_weight(q1, qf1, pix_last.degenerate);
         wc_ff       <= finish_weight(q2, qf2, pix_last.degenerate);
         out_flag_ff <= pix_last;
      end
   end

   assign rsp_weight_a   = wa_ff;
   assign rsp_weight_b   = wb_ff;
   assign rsp_weight_c   = wc_ff;
   assign rsp_inside_res = out_flag_ff.in_tri;
   assign rsp_degenerate = out_flag_ff.degenerate;
   assign rsp_box_min_x  = box_min_x_ff;
   assign rsp_box_min_y  = box_min_y_ff;
   assign rsp_box_max_x  = box_max_x_ff;
   assign rsp_box_max_y  = box_max_y_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Input backpressure only when every stage is full and the output stalls
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a stalled result");

   // Degenerate triangles give zero weights and never report inside
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_weight_a == '0 && rsp_weight_b == '0 && rsp_weight_c == '0
          && !rsp_inside_res))
      else $error("degenerate result with nonzero weights or inside set");

   // Inside means no weight went negative
   a_inside_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inside_res) |->
         (!rsp_weight_a[tbi_pkg::WEIGHT_W-1] && !rsp_weight_b[tbi_pkg::WEIGHT_W-1]
          && !rsp_weight_c[tbi_pkg::WEIGHT_W-1]))
      else $error("inside result carries a negative weight");

endmodule
